// File: rtl/core/rsa_mx_pkg.sv
`default_nettype none

package rsa_mx_pkg;

  // Fixed field widths of the block's channels
  localparam int WORD_W    = 32;
  localparam int PLAIN_W   = 33;
  localparam int CFG_IDX_W = 8;

  // Offset added to every decrypted value
  localparam logic [PLAIN_W-1:0] OFFSET_CHAR = 33'd96;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_EXPONENT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS          = 8'd1;

  typedef struct packed {
    logic [WORD_W-1:0] cipher_word;
    logic              last_in_message;
  } in_t;

  typedef struct packed {
    logic [PLAIN_W-1:0] plain_char;
    logic               last_out;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/core/rsa_modexp_decrypt.sv
`default_nettype none

// Channel   Ports                                          Beat taken when
// --------  ---------------------------------------------  -------------------------
// input     start, busy, in_data (cipher_word, last flag)  start && !busy
// result    out_valid, out_data (plain_char, last_out)     out_valid (one cycle)
// config    cfg_valid, cfg_ready, cfg_index, cfg_data      cfg_valid && cfg_ready
//
// Each word runs through the shared modular shift-and-add unit, operands NW =
// min(MOD_BITS, 32) bits wide, one multiplier bit a cycle: first a reduction of
// the cipher word (WORD_W steps), then one squaring and, for a set exponent bit,
// one multiply per exponent bit. A zero exponent or a modulus below two answers
// in the cycle after the word is taken. Reset (rst_n low, synchronous) loads
// exponent 1 and modulus 2 and drops any word at work. busy is high while a word
// is at work; the result receiver cannot stall, each result is a one-cycle strobe.

module rsa_modexp_decrypt #(
  parameter int MOD_BITS = 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,

  input  wire                                 start,
  output logic                                busy,
  input  wire  rsa_mx_pkg::in_t               in_data,

  output logic                                out_valid,
  output rsa_mx_pkg::out_t                    out_data,

  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [rsa_mx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [rsa_mx_pkg::WORD_W-1:0]       cfg_data
);

  // Modulus width: the register holds at most WORD_W bits
  localparam int NW    = (MOD_BITS < rsa_mx_pkg::WORD_W) ? MOD_BITS : rsa_mx_pkg::WORD_W;
  localparam int SW    = NW + 2;
  localparam int CNT_W = $clog2(rsa_mx_pkg::WORD_W);
  localparam int EXP_W = $clog2(rsa_mx_pkg::WORD_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RED  = 2'd1;
  localparam logic [1:0] ST_SQR  = 2'd2;
  localparam logic [1:0] ST_MUL  = 2'd3;

  // Left-align a multiplier so the unit can take its bits MSB first
  function automatic logic [rsa_mx_pkg::WORD_W-1:0] align_b(input logic [NW-1:0] x);
    align_b = rsa_mx_pkg::WORD_W'(x) << (rsa_mx_pkg::WORD_W - NW);
  endfunction

  // Configuration registers
  logic [rsa_mx_pkg::WORD_W-1:0] exp_r;
  logic [NW-1:0]                 modulus_r;

  // Sequencer and shared unit state
  logic [1:0]                    state_r, state_nxt;
  logic [EXP_W-1:0]              bit_r, bit_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [NW-1:0]                 u_acc_r, u_acc_nxt;
  logic [NW-1:0]                 a_r, a_nxt;
  logic [rsa_mx_pkg::WORD_W-1:0] b_r, b_nxt;
  logic [NW-1:0]                 acc_r, acc_nxt;
  logic [NW-1:0]                 cred_r, cred_nxt;
  logic                          last_r, last_nxt;

  logic                          out_valid_r, out_valid_nxt;
  rsa_mx_pkg::out_t              out_data_r, out_data_nxt;

  // Shared unit: acc = (2 * acc + bit * a) mod n, with acc, a < n
  logic [SW-1:0] t_sum, n1, n2;
  logic [NW-1:0] step_res;

  always_comb begin
    n1    = SW'(modulus_r);
    n2    = SW'({modulus_r, 1'b0});
    t_sum = SW'({u_acc_r, 1'b0}) + SW'(b_r[rsa_mx_pkg::WORD_W-1] ? a_r : '0);
    if (t_sum >= n2) begin
      step_res = NW'(t_sum - n2);
    end else if (t_sum >= n1) begin
      step_res = NW'(t_sum - n1);
    end else begin
      step_res = NW'(t_sum);
    end
  end

  logic accept;
  logic mod_small;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign mod_small = (modulus_r[NW-1:1] == '0);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    bit_nxt       = bit_r;
    cnt_nxt       = cnt_r;
    u_acc_nxt     = u_acc_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    cred_nxt      = cred_r;
    last_nxt      = last_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          last_nxt = in_data.last_in_message;
          if (exp_r == '0) begin
            // Empty power: result is one whatever the modulus
            out_valid_nxt           = 1'b1;
            out_data_nxt.plain_char = rsa_mx_pkg::OFFSET_CHAR + 33'd1;
            out_data_nxt.last_out   = in_data.last_in_message;
          end else if (mod_small) begin
            // Modulus zero or one: every remainder is zero
            out_valid_nxt           = 1'b1;
            out_data_nxt.plain_char = rsa_mx_pkg::OFFSET_CHAR;
            out_data_nxt.last_out   = in_data.last_in_message;
          end else begin
            // Reduce the cipher word as 1 * c mod n
            state_nxt = ST_RED;
            bit_nxt   = EXP_W'(rsa_mx_pkg::WORD_W - 1);
            cnt_nxt   = CNT_W'(rsa_mx_pkg::WORD_W - 1);
            u_acc_nxt = '0;
            a_nxt     = NW'(1);
            b_nxt     = in_data.cipher_word;
            acc_nxt   = NW'(1);
          end
        end
      end
      default: begin
        // Advance the shared unit by one multiplier bit
        u_acc_nxt = step_res;
        b_nxt     = b_r << 1;
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          u_acc_nxt = '0;
          cnt_nxt   = CNT_W'(NW - 1);
          case (state_r)
            ST_RED: begin
              cred_nxt  = step_res;
              state_nxt = ST_SQR;
              a_nxt     = acc_r;
              b_nxt     = align_b(acc_r);
            end
            ST_SQR: begin
              acc_nxt = step_res;
              if (exp_r[bit_r]) begin
                state_nxt = ST_MUL;
                a_nxt     = step_res;
                b_nxt     = align_b(cred_r);
              end else if (bit_r == '0) begin
                state_nxt               = ST_IDLE;
                out_valid_nxt           = 1'b1;
                out_data_nxt.plain_char = rsa_mx_pkg::PLAIN_W'(step_res)
                                          + rsa_mx_pkg::OFFSET_CHAR;
                out_data_nxt.last_out   = last_r;
              end else begin
                bit_nxt = bit_r - EXP_W'(1);
                a_nxt   = step_res;
                b_nxt   = align_b(step_res);
              end
            end
            default: begin
              // Multiply done: move to the next exponent bit or finish
              acc_nxt = step_res;
              if (bit_r == '0) begin
                state_nxt               = ST_IDLE;
                out_valid_nxt           = 1'b1;
                out_data_nxt.plain_char = rsa_mx_pkg::PLAIN_W'(step_res)
                                          + rsa_mx_pkg::OFFSET_CHAR;
                out_data_nxt.last_out   = last_r;
              end else begin
                state_nxt = ST_SQR;
                bit_nxt   = bit_r - EXP_W'(1);
                a_nxt     = step_res;
                b_nxt     = align_b(step_res);
              end
            end
          endcase
        end
      end
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      exp_r       <= rsa_mx_pkg::WORD_W'(1);
      modulus_r   <= NW'(2);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rsa_mx_pkg::CFG_PRIVATE_EXPONENT: exp_r     <= cfg_data;
          rsa_mx_pkg::CFG_MODULUS:          modulus_r <= cfg_data[NW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers hold without reset
  always_ff @(posedge clk) begin
    bit_r      <= bit_nxt;
    cnt_r      <= cnt_nxt;
    u_acc_r    <= u_acc_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    acc_r      <= acc_nxt;
    cred_r     <= cred_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// File: sim/testbench.sv
`default_nettype none

// Checks the RSA decryption core: every ciphertext word beat sent in must come
// back as one result beat carrying (c^d mod n) + 96 and the copied last flag.
// Expected beats are computed here from the current exponent and modulus and
// queued in order; the result side never stalls, so each strobe pops one entry.

module testbench;

  localparam int RUN_LIMIT   = 3_000_000;  // above the worst case for near 300 words
  localparam int TAIL_CYCLES = 2200;       // one full word time, to catch stray beats
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 34;

  // Indexes outside the register list: writes to these must be ignored
  localparam logic [rsa_mx_pkg::CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 8'd2;
  localparam logic [rsa_mx_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LAST  = 8'hFF;

  typedef enum bit {ROW_WORD, ROW_WRITE} row_kind_t;

  // One line of the directed script: either a word beat or a register write
  typedef struct packed {
    row_kind_t                        kind;
    logic [rsa_mx_pkg::CFG_IDX_W-1:0] index;
    logic [rsa_mx_pkg::WORD_W-1:0]    value;
    logic                             last;
    bit                               known;
    logic [rsa_mx_pkg::PLAIN_W-1:0]   plain;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             start = 1'b0;
  logic                             busy;
  rsa_mx_pkg::in_t                  in_data = '0;
  logic                             out_valid;
  rsa_mx_pkg::out_t                 out_data;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [rsa_mx_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rsa_mx_pkg::WORD_W-1:0]    cfg_data = '0;

  // Key as the core should hold it after every accepted register write
  logic [rsa_mx_pkg::WORD_W-1:0] key_exp = 32'd1;
  logic [rsa_mx_pkg::WORD_W-1:0] key_mod = 32'd2;

  rsa_mx_pkg::out_t plain_due[$];
  step_row_t        directed_rows[$];
  rsa_mx_pkg::out_t want;
  int               mismatches = 0;
  int               cycles = 0;

  always #5 clk = ~clk;

  rsa_modexp_decrypt u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Raise c to the held exponent modulo the held modulus, then add the offset.
  // Operands stay below 2^32, so one 64-bit product never overflows.
  function automatic logic [rsa_mx_pkg::PLAIN_W-1:0] decrypt_word(
      input logic [rsa_mx_pkg::WORD_W-1:0] c);
    logic [63:0] acc;
    logic [63:0] base;
    logic [63:0] n;
    int          i;
    if (key_exp == '0) return rsa_mx_pkg::OFFSET_CHAR + 33'd1;
    // modulus zero or one: every remainder is zero
    if (key_mod < 32'd2) return rsa_mx_pkg::OFFSET_CHAR;
    n    = {32'd0, key_mod};
    base = {32'd0, c} % n;
    acc  = 64'd1;
    for (i = rsa_mx_pkg::WORD_W - 1; i >= 0; i--) begin
      acc = (acc * acc) % n;
      if (key_exp[i]) acc = (acc * base) % n;
    end
    return acc[rsa_mx_pkg::PLAIN_W-1:0] + rsa_mx_pkg::OFFSET_CHAR;
  endfunction

  function automatic step_row_t word_row(input logic [rsa_mx_pkg::WORD_W-1:0] c,
                                         input logic last, input bit known,
                                         input logic [rsa_mx_pkg::PLAIN_W-1:0] plain);
    step_row_t r;
    r = '0;
    r.kind  = ROW_WORD;
    r.value = c;
    r.last  = last;
    r.known = known;
    r.plain = plain;
    return r;
  endfunction

  function automatic step_row_t write_row(input logic [rsa_mx_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [rsa_mx_pkg::WORD_W-1:0] val);
    step_row_t r;
    r = '0;
    r.kind  = ROW_WRITE;
    r.index = idx;
    r.value = val;
    return r;
  endfunction

  // Append one line to the directed script
  function automatic void add_row(input step_row_t r);
    directed_rows = {directed_rows, r};
  endfunction

  // Offer one word until the core takes it. Each cycle the sender goes quiet
  // with probability idle_pct; start is driven once per edge, never lowered
  // on acceptance, so back-to-back words keep it high.
  task automatic offer_word(input rsa_mx_pkg::in_t word, input int idle_pct,
                            input rsa_mx_pkg::out_t due);
    bit go;
    do begin
      go = ($urandom_range(99) >= idle_pct);
      start   <= go;
      in_data <= word;
      @(posedge clk);
    end while (!(go && !busy));
    plain_due = {plain_due, due};
  endtask

  // Write one register while the core is idle: drop start, drain every
  // outstanding result, then hold the write beat until cfg_ready takes it.
  task automatic write_reg(input logic [rsa_mx_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rsa_mx_pkg::WORD_W-1:0] val);
    start <= 1'b0;
    while (plain_due.size() != 0 || busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rsa_mx_pkg::CFG_PRIVATE_EXPONENT: key_exp = val;
      rsa_mx_pkg::CFG_MODULUS:          key_mod = val;
      default: ;
    endcase
    // advance so a following write never drives cfg_valid twice in one step
    @(posedge clk);
  endtask

  task automatic flag_mismatch(input string field,
                               input logic [rsa_mx_pkg::PLAIN_W-1:0] want_v,
                               input logic [rsa_mx_pkg::PLAIN_W-1:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", field, want_v, got_v);
  endtask

  // Result side: every strobe is a beat; compare it with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (plain_due.size() == 0) begin
        flag_mismatch("unexpected beat", '0, out_data.plain_char);
      end else begin
        want = plain_due.pop_front();
        if (out_data.plain_char !== want.plain_char)
          flag_mismatch("plain_char", want.plain_char, out_data.plain_char);
        if (out_data.last_out !== want.last_out)
          flag_mismatch("last_out", {32'd0, want.last_out}, {32'd0, out_data.last_out});
      end
    end
  end

  // Watchdog: a hung core or a lost beat ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    step_row_t                     row;
    rsa_mx_pkg::out_t              due;
    rsa_mx_pkg::in_t               word;
    logic [rsa_mx_pkg::WORD_W-1:0] d;
    logic [rsa_mx_pkg::WORD_W-1:0] n;
    logic [rsa_mx_pkg::WORD_W-1:0] c;
    int                            idle_pct;
    int                            p;
    int                            left;
    int                            msg;
    int                            j;

    // Directed script. Known results are typed in; the rest use the predictor.
    // Reset key d = 1, n = 2: result is the low bit of c plus the offset
    add_row(word_row(32'h0000_0000, 1'b0, 1, 33'd96));
    add_row(word_row(32'hFFFF_FFFF, 1'b1, 1, 33'd97));
    // Zero exponent: power is one whatever the word
    add_row(write_row(rsa_mx_pkg::CFG_PRIVATE_EXPONENT, 32'd0));
    add_row(word_row(32'h0001_2345, 1'b0, 1, 33'd97));
    add_row(write_row(rsa_mx_pkg::CFG_MODULUS, 32'hFFFF_FFFF));
    add_row(word_row(32'hFFFF_FFFF, 1'b1, 1, 33'd97));
    // Largest exponent and modulus; a word equal to n reduces to zero
    add_row(write_row(rsa_mx_pkg::CFG_PRIVATE_EXPONENT, 32'hFFFF_FFFF));
    add_row(word_row(32'hFFFF_FFFF, 1'b0, 1, 33'd96));
    add_row(word_row(32'hFFFF_FFFE, 1'b1, 0, '0));
    add_row(word_row(32'h0000_0002, 1'b0, 0, '0));
    // Modulus one, then modulus zero: remainder is always zero
    add_row(write_row(rsa_mx_pkg::CFG_MODULUS, 32'd1));
    add_row(word_row(32'd5, 1'b1, 1, 33'd96));
    add_row(write_row(rsa_mx_pkg::CFG_MODULUS, 32'd0));
    add_row(word_row(32'd7, 1'b0, 1, 33'd96));
    // Zero exponent wins over modulus zero
    add_row(write_row(rsa_mx_pkg::CFG_PRIVATE_EXPONENT, 32'd0));
    add_row(word_row(32'd7, 1'b1, 1, 33'd97));
    // Word not below the modulus is reduced first
    add_row(write_row(rsa_mx_pkg::CFG_PRIVATE_EXPONENT, 32'd1));
    add_row(write_row(rsa_mx_pkg::CFG_MODULUS, 32'd100));
    add_row(word_row(32'd1234, 1'b0, 0, '0));
    // Writes to indexes outside the register list must change nothing
    add_row(write_row(CFG_UNUSED_FIRST, 32'hFFFF_FFFF));
    add_row(write_row(CFG_UNUSED_LAST, 32'hFFFF_FFFF));
    add_row(word_row(32'd1234, 1'b1, 0, '0));
    // Textbook key n = 61 * 53, d = 2753: 2790 decrypts to 65
    add_row(write_row(rsa_mx_pkg::CFG_MODULUS, 32'd3233));
    add_row(write_row(rsa_mx_pkg::CFG_PRIVATE_EXPONENT, 32'd2753));
    add_row(word_row(32'd2790, 1'b0, 1, 33'd161));
    add_row(word_row(32'd3232, 1'b0, 0, '0));
    add_row(word_row(32'd3233, 1'b1, 1, 33'd96));
    // Largest 32-bit prime modulus with an all-ones exponent
    add_row(write_row(rsa_mx_pkg::CFG_MODULUS, 32'hFFFF_FFFB));
    add_row(write_row(rsa_mx_pkg::CFG_PRIVATE_EXPONENT, 32'hFFFF_FFFF));
    add_row(word_row(32'hFFFF_FFFA, 1'b0, 0, '0));
    add_row(word_row(32'd0, 1'b0, 1, 33'd96));
    add_row(word_row(32'd1, 1'b1, 1, 33'd97));

    // Hold reset, then release it once for the whole run
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        write_reg(row.index, row.value);
      end else begin
        due.plain_char = row.known ? row.plain : decrypt_word(row.value);
        due.last_out   = row.last;
        word.cipher_word     = row.value;
        word.last_in_message = row.last;
        offer_word(word, 0, due);
      end
    end

    // Random phases: one key per phase, some extreme, idling varied by phase.
    // The receiver cannot stall, so its idling phases only shape the sender.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin d = 32'hFFFF_FFFF; n = 32'hFFFF_FFFF; end
        1: begin d = $urandom;       n = $urandom | 32'h8000_0000; end
        2: begin d = 32'd0;          n = $urandom; end
        3: begin d = 32'd1;          n = 32'd2; end
        4: begin d = $urandom;       n = 32'd1; end
        5: begin d = $urandom;       n = 32'd0; end
        6: begin d = $urandom;       n = $urandom_range(65535, 2); end
        default: begin d = $urandom_range(255, 1); n = $urandom; end
      endcase
      case (p % 4)
        1:       idle_pct = 66;
        3:       idle_pct = 38;
        default: idle_pct = 0;
      endcase
      write_reg(rsa_mx_pkg::CFG_PRIVATE_EXPONENT, d);
      write_reg(rsa_mx_pkg::CFG_MODULUS, n);
      write_reg(rsa_mx_pkg::CFG_IDX_W'($urandom_range(255, 2)), $urandom);

      // Messages of one to eight words, last flag on the final word;
      // now and then a flag lands at random to break the framing
      left = PHASE_WORDS;
      while (left > 0) begin
        msg = $urandom_range(8, 1);
        if (msg > left) msg = left;
        for (j = 0; j < msg; j++) begin
          case ($urandom_range(9))
            0:       c = $urandom_range(255);
            1:       c = key_mod + rsa_mx_pkg::WORD_W'($urandom_range(2)) - 32'd1;
            2:       c = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default: c = $urandom;
          endcase
          word.cipher_word     = c;
          word.last_in_message = ($urandom_range(9) == 0) ? 1'($urandom_range(1))
                                                          : (j == msg - 1);
          due.plain_char = decrypt_word(c);
          due.last_out   = word.last_in_message;
          offer_word(word, idle_pct, due);
        end
        left -= msg;
      end
    end

    // Drain, then wait one word time for anything unasked
    start <= 1'b0;
    while (plain_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && plain_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
